### rtl/core/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and codes for the escape sequence parser: byte classes,
// final letters, result status and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int BYTE_W   = 8;
    localparam int NUM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 4;
    localparam int KIND_W   = 3;
    localparam int VAL_W    = 4;
    localparam int OUT_W    = 40;

    // byte classes
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ESC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEP   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FINAL = 3'd5;

    // final letters
    localparam logic [VAL_W-1:0] FIN_A  = 4'd0;
    localparam logic [VAL_W-1:0] FIN_B  = 4'd1;
    localparam logic [VAL_W-1:0] FIN_C  = 4'd2;
    localparam logic [VAL_W-1:0] FIN_D  = 4'd3;
    localparam logic [VAL_W-1:0] FIN_H  = 4'd4;
    localparam logic [VAL_W-1:0] FIN_LF = 4'd5;
    localparam logic [VAL_W-1:0] FIN_J  = 4'd6;
    localparam logic [VAL_W-1:0] FIN_K  = 4'd7;
    localparam logic [VAL_W-1:0] FIN_LH = 4'd8;
    localparam logic [VAL_W-1:0] FIN_LL = 4'd9;
    localparam logic [VAL_W-1:0] FIN_LM = 4'd10;
    localparam logic [VAL_W-1:0] FIN_LN = 4'd11;
    localparam logic [VAL_W-1:0] FIN_LS = 4'd12;
    localparam logic [VAL_W-1:0] FIN_LU = 4'd13;

    // result status
    localparam logic [STATUS_W-1:0] ST_MORE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SCROLL   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_UP       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DOWN     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LEFT     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_POSITION = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR_EOL = 4'd8;
    localparam logic [CMD_W-1:0] CMD_WRAP_ON  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_WRAP_OFF = 4'd10;
    localparam logic [CMD_W-1:0] CMD_ATTRS    = 4'd11;
    localparam logic [CMD_W-1:0] CMD_REPORT   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_SAVE     = 4'd13;
    localparam logic [CMD_W-1:0] CMD_RESTORE  = 4'd14;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  val;
    } vtp_class_t;

endpackage

`default_nettype wire

### rtl/core/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front
// Accepts input bytes and sorts each into a class with a digit value or a
// final letter code, pushing the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vtp_pkg::BYTE_W-1:0]    s_tdata,
    input  wire logic                          queue_full,
    output logic                               push,
    output vtp_pkg::vtp_class_t                push_class
);
    import vtp_pkg::*;

    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEP   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    logic [BYTE_W-1:0] digit_off;

    assign s_tready  = !queue_full;
    assign push      = s_tvalid && !queue_full;
    assign digit_off = s_tdata - CH_ZERO;

    always_comb
    begin
        push_class.kind = KIND_FINAL;
        push_class.val  = FIN_A;
        priority if (s_tdata == CH_ESC)
        begin
            push_class.kind = KIND_ESC;
        end
        else if (s_tdata == CH_OPEN)
        begin
            push_class.kind = KIND_OPEN;
        end
        else if (s_tdata == CH_SEP)
        begin
            push_class.kind = KIND_SEP;
        end
        else if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE)
        begin
            push_class.kind = KIND_DIGIT;
            push_class.val  = digit_off[VAL_W-1:0];
        end
        else
        begin
            unique case (s_tdata)
                8'h41:   push_class.val = FIN_A;
                8'h42:   push_class.val = FIN_B;
                8'h43:   push_class.val = FIN_C;
                8'h44:   push_class.val = FIN_D;
                8'h48:   push_class.val = FIN_H;
                8'h66:   push_class.val = FIN_LF;
                8'h4A:   push_class.val = FIN_J;
                8'h4B:   push_class.val = FIN_K;
                8'h68:   push_class.val = FIN_LH;
                8'h6C:   push_class.val = FIN_LL;
                8'h6D:   push_class.val = FIN_LM;
                8'h6E:   push_class.val = FIN_LN;
                8'h73:   push_class.val = FIN_LS;
                8'h75:   push_class.val = FIN_LU;
                default: push_class.kind = KIND_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/vtp_queue.sv
// ----------------------------------------------------------------------------
// vtp_queue
// Short first-in first-out queue of classified bytes between the front and
// the back; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_queue #(
    parameter int DEPTH = vtp_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  vtp_pkg::vtp_class_t       push_class,
    output logic                      full,
    input  wire logic                 pop,
    output vtp_pkg::vtp_class_t       pop_class,
    output logic                      not_empty
);
    import vtp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vtp_class_t        store_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_class = store_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= push_class;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

### rtl/core/vtp_back.sv
// ----------------------------------------------------------------------------
// vtp_back
// Sequence state machine: takes classified bytes from the queue, tracks the
// numbers and flags, checks final rules and registers one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        queue_valid,
    input  vtp_pkg::vtp_class_t              queue_class,
    output logic                             pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vtp_pkg::OUT_W-1:0]        m_tdata
);
    import vtp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [NUM_W-1:0]  first_reg, first_next;
    logic [NUM_W-1:0]  second_reg, second_next;
    logic              first_seen_reg, first_seen_next;
    logic              second_seen_reg, second_seen_next;
    logic              sep_seen_reg, sep_seen_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [STATUS_W-1:0] status_c;
    logic [CMD_W-1:0]    cmd_c;
    logic [CMD_W-1:0]    fin_cmd;
    logic [NUM_W-1:0]    acc_in;
    logic [NUM_W+3:0]    acc_sum;
    logic [NUM_W-1:0]    acc_sat;
    logic                bad_shape, need_none;

    assign pop      = queue_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // digit accumulate with saturation
    assign acc_in  = sep_seen_reg ? second_reg : first_reg;
    assign acc_sum = {4'b0000, acc_in} * (NUM_W+4)'(10)
                     + {{NUM_W{1'b0}}, queue_class.val};
    assign acc_sat = (|acc_sum[NUM_W+3:NUM_W]) ? {NUM_W{1'b1}} : acc_sum[NUM_W-1:0];

    assign bad_shape = sep_seen_reg || !first_seen_reg || second_seen_reg;
    assign need_none = sep_seen_reg || first_seen_reg || second_seen_reg;

    always_comb
    begin
        unique case (queue_class.val)
            FIN_A:  fin_cmd = bad_shape ? CMD_NONE : CMD_UP;
            FIN_B:  fin_cmd = bad_shape ? CMD_NONE : CMD_DOWN;
            FIN_C:  fin_cmd = bad_shape ? CMD_NONE : CMD_RIGHT;
            FIN_D:  fin_cmd = bad_shape ? CMD_NONE : CMD_LEFT;
            FIN_H,
            FIN_LF: fin_cmd = (!first_seen_reg || !second_seen_reg) ? CMD_NONE : CMD_POSITION;
            FIN_J:  fin_cmd = (bad_shape || first_reg != NUM_W'(2)) ? CMD_NONE : CMD_CLEAR;
            FIN_K:  fin_cmd = need_none ? CMD_NONE : CMD_CLEAR_EOL;
            FIN_LH: fin_cmd = (!first_seen_reg || second_seen_reg || first_reg != NUM_W'(7))
                              ? CMD_NONE : CMD_WRAP_ON;
            FIN_LL: fin_cmd = (!first_seen_reg || second_seen_reg) ? CMD_NONE : CMD_WRAP_OFF;
            FIN_LM: fin_cmd = !first_seen_reg ? CMD_NONE : CMD_ATTRS;
            FIN_LN: fin_cmd = (!first_seen_reg || second_seen_reg || first_reg != NUM_W'(6))
                              ? CMD_NONE : CMD_REPORT;
            FIN_LS: fin_cmd = need_none ? CMD_NONE : CMD_SAVE;
            FIN_LU: fin_cmd = need_none ? CMD_NONE : CMD_RESTORE;
            default: fin_cmd = CMD_NONE;
        endcase
    end

    always_comb
    begin
        status_c         = ST_MORE;
        cmd_c            = CMD_NONE;
        phase_next       = phase_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        first_seen_next  = first_seen_reg;
        second_seen_next = second_seen_reg;
        sep_seen_next    = sep_seen_reg;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (queue_class.kind == KIND_FINAL && queue_class.val == FIN_D)
                begin
                    status_c = ST_DONE;
                    cmd_c    = CMD_SCROLL;
                end
                else if (queue_class.kind == KIND_OPEN)
                begin
                    phase_next = PH_CSI;
                end
                else
                begin
                    status_c = ST_BAD;
                end
            end
            PH_CSI:
            begin
                unique case (queue_class.kind)
                    KIND_DIGIT:
                    begin
                        if (!sep_seen_reg)
                        begin
                            first_next      = acc_sat;
                            first_seen_next = 1'b1;
                        end
                        else
                        begin
                            second_next      = acc_sat;
                            second_seen_next = 1'b1;
                        end
                    end
                    KIND_SEP:
                    begin
                        if (sep_seen_reg)
                        begin
                            status_c = ST_BAD;
                        end
                        else
                        begin
                            sep_seen_next = 1'b1;
                        end
                    end
                    KIND_FINAL:
                    begin
                        cmd_c    = fin_cmd;
                        status_c = (fin_cmd != CMD_NONE) ? ST_DONE : ST_BAD;
                    end
                    default: status_c = ST_BAD;
                endcase
            end
            default:
            begin
                if (queue_class.kind == KIND_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    status_c = ST_BAD;
                end
            end
        endcase
        if (status_c != ST_MORE)
        begin
            phase_next       = PH_IDLE;
            first_next       = '0;
            second_next      = '0;
            first_seen_next  = 1'b0;
            second_seen_next = 1'b0;
            sep_seen_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            first_reg       <= '0;
            second_reg      <= '0;
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
            sep_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                first_reg       <= first_next;
                second_reg      <= second_next;
                first_seen_reg  <= first_seen_next;
                second_seen_reg <= second_seen_next;
                sep_seen_reg    <= sep_seen_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result fields: status, command, first, second, has_second, pad
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cmd_c != CMD_NONE && cmd_c != CMD_SCROLL)
            begin
                out_data_reg <= {1'b0, second_seen_reg, second_reg, first_reg, cmd_c, status_c};
            end
            else
            begin
                out_data_reg <= {1'b0, 1'b0, {NUM_W{1'b0}}, {NUM_W{1'b0}}, cmd_c, status_c};
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && status_c != ST_MORE) |=> (phase_reg == PH_IDLE && !first_seen_reg
                                          && !second_seen_reg && !sep_seen_reg))
        else $error("state not cleared after a finished sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg[1:0] == ST_DONE) == (out_data_reg[5:2] != CMD_NONE)))
        else $error("command code disagrees with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        second_seen_reg |-> sep_seen_reg)
        else $error("second number without separator");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !pop)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### rtl/core/vt100_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// vt100_escape_sequence_parser
// Byte-stream parser for ESC D and ESC [ sequences with up to two numbers.
// An accepted byte is stored in the queue; the back pops it and registers its result on m_tdata.
// Throughput: one byte per clock unless m_tready stalls the output, set by the state update in the back.
// A short queue sits between classifier and state machine; the output is registered.
// Reset clears the parse state to idle, empties the queue and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module vt100_escape_sequence_parser #(
    parameter int QUEUE_DEPTH = vtp_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status, command, first_number, second_number, has_second
);
    import vtp_pkg::*;

    vtp_class_t front_class;
    vtp_class_t back_class;
    logic       push, queue_full, pop, queue_valid;

    vtp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_class (front_class)
    );

    vtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (front_class),
        .full       (queue_full),
        .pop        (pop),
        .pop_class  (back_class),
        .not_empty  (queue_valid)
    );

    vtp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_valid (queue_valid),
        .queue_class (back_class),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the escape sequence parser. Bytes go in on the slave
// side under random valid gaps. A local copy of the parse state predicts the
// status, command and numbers for every accepted byte. Each result on the
// master side, taken under random ready stalls, is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import vtp_pkg::*;

    localparam logic [7:0] ESC_CHAR = 8'h1B;
    localparam int IDLE_PCT = 21;
    localparam int NUM_ITEMS = 750;
    localparam int STEADY_LO = 300;
    localparam int STEADY_HI = 450;
    localparam string FINALS = "ABCDHfJKhlmnsu";

    typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_CSI} parse_phase_t;

    typedef struct packed {
        logic              has_second;
        logic [NUM_W-1:0]  second;
        logic [NUM_W-1:0]  first;
        logic [CMD_W-1:0]  command;
        logic [STATUS_W-1:0] status;
    } parse_result_t;

    typedef struct {
        logic [7:0] data;
        bit         steady;
        bit         drain;
    } byte_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // byte_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // status, command, first_number, second_number, has_second

    byte_req_t     byte_reqs[$];
    parse_result_t expected_results[$];
    int            sent_cnt = 0;
    int            got_cnt = 0;
    int            err_cnt = 0;
    bit            quiet = 1'b0;

    // predictor state
    parse_phase_t     ph = PH_IDLE;
    logic [NUM_W-1:0] num_a = '0;
    logic [NUM_W-1:0] num_b = '0;
    bit               got_a = 1'b0;
    bit               got_b = 1'b0;
    bit               got_sep = 1'b0;

    vt100_escape_sequence_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] v, logic [7:0] c);
        int unsigned n;
        n = v * 10 + (c - "0");
        return (n > 65535) ? 16'hFFFF : n[NUM_W-1:0];
    endfunction

    function automatic logic [CMD_W-1:0] final_code(logic [7:0] b);
        logic [CMD_W-1:0] c;
        c = CMD_NONE;
        case (b)
            "A": if (!got_sep && got_a && !got_b) c = CMD_UP;
            "B": if (!got_sep && got_a && !got_b) c = CMD_DOWN;
            "C": if (!got_sep && got_a && !got_b) c = CMD_RIGHT;
            "D": if (!got_sep && got_a && !got_b) c = CMD_LEFT;
            "H", "f": if (got_a && got_b) c = CMD_POSITION;
            "J": if (!got_sep && got_a && !got_b && num_a == 2) c = CMD_CLEAR;
            "K": if (!got_sep && !got_a && !got_b) c = CMD_CLEAR_EOL;
            "h": if (got_a && !got_b && num_a == 7) c = CMD_WRAP_ON;
            "l": if (got_a && !got_b) c = CMD_WRAP_OFF;
            "m": if (got_a) c = CMD_ATTRS;
            "n": if (got_a && !got_b && num_a == 6) c = CMD_REPORT;
            "s": if (!got_sep && !got_a && !got_b) c = CMD_SAVE;
            "u": if (!got_sep && !got_a && !got_b) c = CMD_RESTORE;
            default: c = CMD_NONE;
        endcase
        return c;
    endfunction

    // advances the parse state by one byte and returns its result
    function automatic parse_result_t parse_byte(logic [7:0] b);
        parse_result_t r;
        r = '0;
        r.status = ST_MORE;
        if (ph == PH_ESC)
        begin
            if (b == "D")
            begin
                r.status = ST_DONE;
                r.command = CMD_SCROLL;
            end
            else if (b == "[")
                ph = PH_CSI;
            else
                r.status = ST_BAD;
        end
        else if (ph == PH_CSI)
        begin
            if (b >= "0" && b <= "9")
            begin
                if (!got_sep)
                begin
                    num_a = add_digit(num_a, b);
                    got_a = 1'b1;
                end
                else
                begin
                    num_b = add_digit(num_b, b);
                    got_b = 1'b1;
                end
            end
            else if (b == ";")
            begin
                if (got_sep)
                    r.status = ST_BAD;
                else
                    got_sep = 1'b1;
            end
            else
            begin
                r.command = final_code(b);
                if (r.command != CMD_NONE)
                begin
                    r.status = ST_DONE;
                    r.first = num_a;
                    r.second = num_b;
                    r.has_second = got_b;
                end
                else
                    r.status = ST_BAD;
            end
        end
        else if (b == ESC_CHAR)
            ph = PH_ESC;
        else
            r.status = ST_BAD;
        if (r.status != ST_MORE)
        begin
            ph = PH_IDLE;
            num_a = '0;
            num_b = '0;
            got_a = 1'b0;
            got_b = 1'b0;
            got_sep = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_req_t q;
        q.data = b;
        q.steady = (byte_reqs.size() >= STEADY_LO && byte_reqs.size() < STEADY_HI);
        q.drain = (byte_reqs.size() == 24 || byte_reqs.size() == 500);
        byte_reqs.push_back(q);
    endtask

    task automatic push_number(input int v, input bit lead_zero);
        string s;
        s = $sformatf("%0d", v);
        if (lead_zero)
            push_byte("0");
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic int pick_value(logic [7:0] fin);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && fin == "J")
            return 2;
        if (r < 45 && fin == "h")
            return 7;
        if (r < 45 && fin == "n")
            return 6;
        if (r < 55)
            return $urandom_range(0, 9);
        if (r < 88)
            return $urandom_range(0, 999);
        if (r < 94)
            return $urandom_range(60000, 70000);
        return $urandom_range(100000, 9999999);
    endfunction

    task automatic gen_sequence();
        logic [7:0] fin;
        int r;
        int shape;
        r = $urandom_range(0, 99);
        fin = FINALS[$urandom_range(0, FINALS.len() - 1)];
        if (r < 8)
        begin
            push_byte(ESC_CHAR);
            push_byte("D");
        end
        else if (r < 82)
        begin
            push_byte(ESC_CHAR);
            push_byte("[");
            // bias the parameter shape toward what the final letter accepts
            if ($urandom_range(0, 99) < 60)
            begin
                case (fin)
                    "H", "f": shape = 2;
                    "K", "s", "u": shape = 0;
                    "m": shape = $urandom_range(1, 2);
                    default: shape = 1;
                endcase
            end
            else
                shape = $urandom_range(0, 4);
            if (shape == 1 || shape == 2)
                push_number(pick_value(fin), $urandom_range(0, 9) == 0);
            if (shape >= 2)
                push_byte(";");
            if (shape == 2 || shape == 3)
                push_number(pick_value(fin), $urandom_range(0, 9) == 0);
            push_byte(fin);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: push_byte(8'($urandom_range(0, 255)));
                1:
                begin
                    push_byte(ESC_CHAR);
                    push_byte(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    push_byte(ESC_CHAR);
                    push_byte("[");
                    push_number($urandom_range(0, 99), 1'b0);
                    push_byte(";");
                    push_byte(";");
                end
                default:
                begin
                    push_byte(ESC_CHAR);
                    push_byte("[");
                    if ($urandom_range(0, 1))
                        push_number($urandom_range(0, 99), 1'b0);
                    push_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // byte source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (byte_reqs.size() != 0
                && !(byte_reqs[0].drain && (s_tvalid || sent_cnt != got_cnt))
                && (byte_reqs[0].steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= byte_reqs[0].data;
                quiet <= byte_reqs[0].steady;
                byte_reqs.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // predict on accepted requests, check on accepted results
    always @(posedge clk)
    begin
        parse_result_t want;
        parse_result_t seen;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(parse_byte(s_tdata));
                sent_cnt <= sent_cnt + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got_cnt <= got_cnt + 1;
                seen = m_tdata[38:0];
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  seen.status, want.status));
                    if (seen.command !== want.command)
                        report_mismatch($sformatf("command %0d, want %0d",
                                                  seen.command, want.command));
                    if (seen.first !== want.first)
                        report_mismatch($sformatf("first_number %0d, want %0d",
                                                  seen.first, want.first));
                    if (seen.second !== want.second)
                        report_mismatch($sformatf("second_number %0d, want %0d",
                                                  seen.second, want.second));
                    if (seen.has_second !== want.has_second)
                        report_mismatch($sformatf("has_second %0d, want %0d",
                                                  seen.has_second, want.has_second));
                    if (m_tdata[39] !== 1'b0)
                        report_mismatch("pad bit set");
                end
            end
        end
    end

    initial
    begin
        // bytes outside a sequence, scroll, bad byte after escape
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ESC_CHAR);
        push_byte("D");
        push_byte(ESC_CHAR);
        push_byte(8'hFF);
        // clear with its required value
        push_byte(ESC_CHAR);
        push_byte("[");
        push_byte("2");
        push_byte("J");
        // second separator
        push_byte(ESC_CHAR);
        push_byte("[");
        push_byte(";");
        push_byte(";");
        // saturated number
        push_byte(ESC_CHAR);
        push_byte("[");
        push_number(999999, 1'b0);
        push_byte("m");
        // unknown byte inside a sequence
        push_byte(ESC_CHAR);
        push_byte("[");
        push_byte(8'h00);
        while (byte_reqs.size() < NUM_ITEMS)
            gen_sequence();

        @(posedge rst_n);
        while (byte_reqs.size() != 0 || s_tvalid || sent_cnt != got_cnt)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_results.size()));
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/vtp_pkg.sv
rtl/core/vtp_front.sv
rtl/core/vtp_queue.sv
rtl/core/vtp_back.sv
rtl/core/vt100_escape_sequence_parser.sv
dv/tb_top.sv
